FILE: rtl/source_text_tokenizer_assert.svh
// Assertion macros for the source text tokenizer checker.
// Needs a clock and reset signal in the scope where a macro is used.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// same-cycle implication, off during reset
`define STT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define STT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, always on
`define STT_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/stt_pkg.sv
// Shared types, token kind codes and byte classifiers for the tokenizer.
// No dependencies.
`timescale 1ns / 1ps

package stt_pkg;

   localparam logic [3:0] KIND_NUMBER    = 4'd0;
   localparam logic [3:0] KIND_PRINT     = 4'd1;
   localparam logic [3:0] KIND_SEPARATOR = 4'd2;
   localparam logic [3:0] KIND_IDENT     = 4'd3;
   localparam logic [3:0] KIND_OPERATOR  = 4'd4;
   localparam logic [3:0] KIND_STRING    = 4'd5;
   localparam logic [3:0] KIND_EXIT      = 4'd6;
   localparam logic [3:0] KIND_FUNC      = 4'd7;
   localparam logic [3:0] KIND_END       = 4'd8;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CHAR_NUL       = 8'h00;

   localparam logic [2:0] KW_ALL = 3'b111;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_NUMBER = 4'b0010,
      MODE_WORD   = 4'b0100,
      MODE_STRING = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [7:0]  symbol;
   } token_type;

   // tokens from one byte: first, and second when two is set
   typedef struct packed {
      logic      two;
      token_type first;
      token_type second;
   } pair_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_separator(logic [7:0] c);
      return (c == ";") || (c == "(") || (c == ")");
   endfunction

   function automatic logic is_operator(logic [7:0] c);
      return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "%") ||
             (c == "=") || (c == "&") || (c == "|") || (c == "<") || (c == ">") ||
             (c == "!");
   endfunction

   // bit 0 exit, bit 1 println, bit 2 func: keyword has c at index idx
   function automatic logic [2:0] kw_match(logic [2:0] idx, logic [7:0] c);
      logic [7:0] e;
      logic [7:0] p;
      logic [7:0] f;
      e = 8'h00;
      p = 8'h00;
      f = 8'h00;
      case (idx)
         3'd0: begin e = "e"; p = "p"; f = "f"; end
         3'd1: begin e = "x"; p = "r"; f = "u"; end
         3'd2: begin e = "i"; p = "i"; f = "n"; end
         3'd3: begin e = "t"; p = "n"; f = "c"; end
         3'd4: p = "t";
         3'd5: p = "l";
         3'd6: p = "n";
         default: ;
      endcase
      return {(f != 8'h00) && (f == c), (p != 8'h00) && (p == c),
              (e != 8'h00) && (e == c)};
   endfunction

endpackage

FILE: rtl/source_text_tokenizer.sv
// Source text tokenizer, top level.
// Input side: push a byte with req_push while req_full is low; a zero byte
// ends the text, flushes any pending token and adds an end token.
// Result side: while rsp_empty is low the oldest token is on the rsp_ ports;
// rsp_pop transfers it. rsp_last_of_run marks the last token of one byte.
// A byte is taken every cycle while the pair queue has room; each byte gives
// zero, one or two tokens. A token passes the pair queue, then the output
// register; tokens leave at one per cycle while rsp_pop is high.
// The front end updates its scan state in the cycle the byte is taken, so
// back-to-back bytes never wait on each other; a byte that yields two tokens
// holds the result register for two transfers.
// When the receiver stalls, tokens collect in a QUEUE_DEPTH-entry pair queue
// plus the output register; req_full rises once the queue is full.
// Reset clears the scan state, the position count and the queue, and drops
// any result not yet transferred.
// Depends on stt_pkg, stt_front, stt_queue and stt_back.
`timescale 1ns / 1ps

module source_text_tokenizer import stt_pkg::*; #(
   parameter int POSITION_BITS = 16,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_character,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic [7:0]  rsp_symbol,
   output logic        rsp_last_of_run
);

   logic     wr_en;
   pair_type wr_pair;
   logic     q_full, q_nonempty, q_rd;
   pair_type q_pair;

   assign req_full = q_full;

   stt_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (q_full),
      .req_character(req_character),
      .wr_en        (wr_en),
      .wr_pair      (wr_pair)
   );

   stt_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_pair (wr_pair),
      .full    (q_full),
      .nonempty(q_nonempty),
      .rd_en   (q_rd),
      .rd_pair (q_pair)
   );

   stt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_nonempty      (q_nonempty),
      .q_pair          (q_pair),
      .q_rd            (q_rd),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_start (rsp_token_start),
      .rsp_token_length(rsp_token_length),
      .rsp_symbol      (rsp_symbol),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

FILE: rtl/stt_front.sv
// Front end: takes source bytes, keeps the scan state, builds token pairs.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_front import stt_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_character,
   output logic       wr_en,
   output pair_type   wr_pair
);

   localparam int PB = POSITION_BITS;

   mode_type          mode_ff, mode_in;
   logic [PB-1:0]     start_ff, start_in;
   logic [PB-1:0]     len_ff, len_in;
   logic [PB-1:0]     pos_ff, pos_in;
   logic [2:0]        flags_ff, flags_in;
   logic              bs_ff, bs_in;

   logic [7:0]        c;
   logic              accept;
   logic              digit, alpha, word_ch, quote, is_nul;
   logic              taken, flush_fire, new_fire;
   logic [PB-1:0]     pos_inc, len_inc;
   logic [2:0]        kw_now;
   token_type         flush_tok, new_tok;

   function automatic logic [15:0] to16(logic [PB-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[15:0];
   endfunction

   assign c       = req_character;
   assign accept  = req_push && !req_full;
   assign digit   = is_digit(c);
   assign alpha   = is_alpha(c);
   assign word_ch = digit || alpha || (c == CHAR_UNDERSCORE);
   assign quote   = (c == CHAR_QUOTE);
   assign is_nul  = (c == CHAR_NUL);
   assign pos_inc = (pos_ff == '1) ? pos_ff : pos_ff + PB'(1);
   assign len_inc = (len_ff == '1) ? len_ff : len_ff + PB'(1);
   assign kw_now  = (len_ff[PB-1:3] == '0) ? kw_match(len_ff[2:0], c) : 3'b000;

   always_comb begin
      taken = !is_nul && (((mode_ff == MODE_NUMBER) && digit) ||
                          ((mode_ff == MODE_WORD) && word_ch) ||
                          ((mode_ff == MODE_STRING) && !(quote && !bs_ff)));
      flush_fire = (mode_ff != MODE_IDLE) &&
                   (is_nul || ((mode_ff == MODE_NUMBER) && !digit) ||
                    ((mode_ff == MODE_WORD) && !word_ch) ||
                    ((mode_ff == MODE_STRING) && quote && !bs_ff));
      if ((mode_ff == MODE_STRING) && quote && !bs_ff) begin
         taken = 1'b1;
      end
      new_fire = is_nul || (!taken && (is_separator(c) || is_operator(c)));
   end

   always_comb begin
      flush_tok.start  = to16(start_ff);
      flush_tok.length = to16(len_ff);
      flush_tok.symbol = 8'h00;
      case (mode_ff)
         MODE_NUMBER: flush_tok.kind = KIND_NUMBER;
         MODE_STRING: flush_tok.kind = KIND_STRING;
         MODE_WORD: begin
            if (flags_ff[0] && (len_ff == PB'(4))) begin
               flush_tok.kind = KIND_EXIT;
            end else if (flags_ff[1] && (len_ff == PB'(7))) begin
               flush_tok.kind = KIND_PRINT;
            end else if (flags_ff[2] && (len_ff == PB'(4))) begin
               flush_tok.kind = KIND_FUNC;
            end else begin
               flush_tok.kind = KIND_IDENT;
            end
         end
         default: flush_tok.kind = KIND_IDENT;
      endcase

      new_tok.start = to16(pos_ff);
      if (is_nul) begin
         new_tok.kind   = KIND_END;
         new_tok.length = 16'd0;
         new_tok.symbol = 8'h00;
      end else begin
         new_tok.kind   = is_separator(c) ? KIND_SEPARATOR : KIND_OPERATOR;
         new_tok.length = 16'd1;
         new_tok.symbol = c;
      end

      wr_en = accept && (flush_fire || new_fire);
      if (flush_fire) begin
         wr_pair.two    = new_fire;
         wr_pair.first  = flush_tok;
         wr_pair.second = new_tok;
      end else begin
         wr_pair.two    = 1'b0;
         wr_pair.first  = new_tok;
         wr_pair.second = new_tok;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      len_in   = len_ff;
      pos_in   = pos_inc;
      flags_in = flags_ff;
      bs_in    = bs_ff;
      if (is_nul) begin
         mode_in  = MODE_IDLE;
         start_in = '0;
         len_in   = '0;
         pos_in   = '0;
         flags_in = KW_ALL;
         bs_in    = 1'b0;
      end else begin
         if (taken && !flush_fire) begin
            len_in = len_inc;
            if (mode_ff == MODE_WORD) begin
               flags_in = flags_ff & kw_now;
            end
            if (mode_ff == MODE_STRING) begin
               bs_in = (c == CHAR_BACKSLASH) && !bs_ff;
            end
         end
         if (flush_fire) begin
            mode_in  = MODE_IDLE;
            start_in = '0;
            len_in   = '0;
            flags_in = KW_ALL;
            bs_in    = 1'b0;
         end
         if (!taken) begin
            if (is_separator(c)) begin
               // emitted directly, no state change
            end else if (digit) begin
               mode_in  = MODE_NUMBER;
               start_in = pos_ff;
               len_in   = PB'(1);
            end else if (alpha) begin
               mode_in  = MODE_WORD;
               start_in = pos_ff;
               len_in   = PB'(1);
               flags_in = kw_match(3'd0, c);
            end else if (quote) begin
               mode_in  = MODE_STRING;
               start_in = pos_inc;
               len_in   = '0;
               bs_in    = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         len_ff   <= '0;
         pos_ff   <= '0;
         flags_ff <= KW_ALL;
         bs_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         flags_ff <= flags_in;
         bs_ff    <= bs_in;
      end
   end

endmodule

FILE: rtl/stt_queue.sv
// Short queue of token pairs between front and back end.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_queue import stt_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  pair_type wr_pair,
   output logic     full,
   output logic     nonempty,
   input  logic     rd_en,
   output pair_type rd_pair
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   pair_type        entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_wr, do_rd;

   assign full     = (count_ff == CW'(DEPTH));
   assign nonempty = (count_ff != '0);
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && nonempty;
   assign rd_pair  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_pair;
      end
   end

endmodule

FILE: rtl/stt_back.sv
// Back end: output register that hands out the tokens of a pair one per transfer.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_back import stt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_nonempty,
   input  pair_type    q_pair,
   output logic        q_rd,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic [7:0]  rsp_symbol,
   output logic        rsp_last_of_run
);

   pair_type   hold_ff;
   logic       valid_ff, valid_in;
   logic       sel_ff, sel_in;
   logic       last_now, xfer, load;
   token_type  tok;

   assign last_now = sel_ff || !hold_ff.two;
   assign xfer     = rsp_pop && valid_ff;
   assign load     = q_nonempty && (!valid_ff || (xfer && last_now));
   assign q_rd     = load;
   assign tok      = sel_ff ? hold_ff.second : hold_ff.first;

   assign rsp_empty        = !valid_ff;
   assign rsp_token_kind   = tok.kind;
   assign rsp_token_start  = tok.start;
   assign rsp_token_length = tok.length;
   assign rsp_symbol       = tok.symbol;
   assign rsp_last_of_run  = last_now;

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (load) begin
         valid_in = 1'b1;
         sel_in   = 1'b0;
      end else if (xfer && last_now) begin
         valid_in = 1'b0;
         sel_in   = 1'b0;
      end else if (xfer) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= q_pair;
      end
   end

endmodule

FILE: rtl/stt_checker.sv
// Port-level checks for the source text tokenizer, bound to the top level.
// Depends on stt_pkg and source_text_tokenizer_assert.svh.
`timescale 1ns / 1ps
`include "source_text_tokenizer_assert.svh"

module stt_checker import stt_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [3:0]  rsp_token_kind,
   input logic [15:0] rsp_token_length,
   input logic [7:0]  rsp_symbol,
   input logic        rsp_last_of_run
);

   logic rsp_valid;
   logic is_end;
   logic single_char;
   logic single_ok;

   assign rsp_valid   = !rsp_empty;
   assign is_end      = (rsp_token_kind == KIND_END);
   assign single_char = (rsp_token_kind == KIND_SEPARATOR) ||
                        (rsp_token_kind == KIND_OPERATOR);
   assign single_ok   = (rsp_token_length == 16'd1) && (rsp_symbol != 8'h00);

   `STT_ASSERT_RST(a_reset_empty, reset, rsp_empty, "result present after reset")
   `STT_ASSERT_NXT(a_hold_valid, rsp_valid && !rsp_pop, rsp_valid, "result dropped")
   `STT_ASSERT_IMP(a_end_last, rsp_valid && is_end, rsp_last_of_run, "end token not last")
   `STT_ASSERT_IMP(a_single_char, rsp_valid && single_char, single_ok, "bad single char token")
   `STT_ASSERT_IMP(a_symbol_zero, rsp_valid && !single_char, rsp_symbol == 8'h00, "symbol set")

endmodule

bind source_text_tokenizer stt_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_token_kind  (rsp_token_kind),
   .rsp_token_length(rsp_token_length),
   .rsp_symbol      (rsp_symbol),
   .rsp_last_of_run (rsp_last_of_run)
);

FILE: verif/tb.sv
// Self-checking bench for source_text_tokenizer: a directed byte table, a long number,
// then random texts, scored against a local predictor or typed table tokens.
// Depends on stt_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module tb;
   import stt_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BYTES   = 1500;
   localparam int LONG_DIGITS    = 60;
   localparam string OP_CHARS    = "+-*/%=&|<>!";

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [7:0]  sym;
      logic        is_last;
   } token_rec_type;

   // n_typed nonzero: tokens typed in the row replace the predicted ones
   typedef struct packed {
      logic [7:0]    ch;
      logic [1:0]    n_typed;
      token_rec_type t0;
      token_rec_type t1;
   } stim_row_type;

   typedef enum logic [1:0] {POP_ALWAYS, POP_RANDOM, POP_BURSTY} pop_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_character = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic [7:0]  rsp_symbol;
   logic        rsp_last_of_run;

   source_text_tokenizer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_character    (req_character),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_symbol       (rsp_symbol),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // scanner state mirrored by the predictor
   mode_type    cur_mode = MODE_IDLE;
   logic [15:0] tok_start = 16'd0;
   logic [15:0] tok_len = 16'd0;
   logic [15:0] text_pos = 16'd0;
   logic [2:0]  kw_live = KW_ALL;
   logic        escape_next = 1'b0;

   string keywords[3] = '{"exit", "println", "func"};
   string kw_forms[14] = '{"exit", "println", "func", "exi", "exits", "printl", "println9",
                           "fun", "func_", "Exit", "e", "p_1", "f", "xexit"};

   token_rec_type byte_tokens[$];
   token_rec_type tokens_due[$];
   logic [7:0]    text_q[$];

   int unsigned errors = 0;
   int unsigned checked = 0;
   int unsigned bytes_sent = 0;
   int unsigned texts_sent = 0;
   int unsigned burst_left = 0;
   int unsigned kind_seen[9];

   pop_style_type pop_mode = POP_ALWAYS;
   int            pop_mode_left = 0;
   int            pop_hold = 0;
   logic          pop_level = 1'b1;

   function automatic token_rec_type tk(logic [3:0] kind, logic [15:0] start,
                                        logic [15:0] len, logic [7:0] sym, logic is_last);
      token_rec_type t;
      t.kind = kind;
      t.start = start;
      t.len = len;
      t.sym = sym;
      t.is_last = is_last;
      return t;
   endfunction

   function automatic stim_row_type row(logic [7:0] ch, logic [1:0] n_typed = 2'd0,
                                        token_rec_type a = '0, token_rec_type b = '0);
      stim_row_type r;
      r.ch = ch;
      r.n_typed = n_typed;
      r.t0 = a;
      r.t1 = b;
      return r;
   endfunction

   function automatic void put_byte(logic [7:0] b);
      text_q.insert(text_q.size(), b);
   endfunction

   function automatic logic [15:0] bump(logic [15:0] x);
      return (x == 16'hffff) ? x : x + 16'd1;
   endfunction

   function automatic logic num_char(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic letter_char(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
   endfunction

   function automatic logic op_char(logic [7:0] c);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < OP_CHARS.len(); k++)
         if (OP_CHARS[k] == c) hit = 1'b1;
      return hit;
   endfunction

   // drop each keyword that does not have c at index idx
   function automatic logic [2:0] kw_filter(logic [2:0] live, logic [15:0] idx, logic [7:0] c);
      logic [2:0] keep;
      keep = live;
      for (int k = 0; k < 3; k++)
         if (idx >= keywords[k].len() || keywords[k][idx] != c) keep[k] = 1'b0;
      return keep;
   endfunction

   function automatic void add_token(logic [3:0] kind, logic [15:0] start, logic [15:0] len,
                                     logic [7:0] sym);
      byte_tokens.insert(byte_tokens.size(), tk(kind, start, len, sym, 1'b0));
   endfunction

   function automatic void close_pending();
      logic [3:0] kind;
      case (cur_mode)
         MODE_NUMBER: add_token(KIND_NUMBER, tok_start, tok_len, 8'h00);
         MODE_WORD: begin
            if (kw_live[0] && tok_len == 16'd4) kind = KIND_EXIT;
            else if (kw_live[1] && tok_len == 16'd7) kind = KIND_PRINT;
            else if (kw_live[2] && tok_len == 16'd4) kind = KIND_FUNC;
            else kind = KIND_IDENT;
            add_token(kind, tok_start, tok_len, 8'h00);
         end
         MODE_STRING: add_token(KIND_STRING, tok_start, tok_len, 8'h00);
         default: ;
      endcase
      cur_mode = MODE_IDLE;
      tok_start = 16'd0;
      tok_len = 16'd0;
      kw_live = KW_ALL;
      escape_next = 1'b0;
   endfunction

   // tokens caused by one byte land in byte_tokens
   function automatic void scan_byte(logic [7:0] c);
      logic taken;
      taken = 1'b0;
      byte_tokens.delete();
      if (c == CHAR_NUL) begin
         close_pending();
         add_token(KIND_END, text_pos, 16'd0, 8'h00);
         text_pos = 16'd0;
      end else begin
         case (cur_mode)
            MODE_NUMBER: begin
               if (num_char(c)) begin
                  tok_len = bump(tok_len);
                  taken = 1'b1;
               end else begin
                  close_pending();
               end
            end
            MODE_WORD: begin
               if (letter_char(c) || num_char(c) || c == CHAR_UNDERSCORE) begin
                  kw_live = kw_filter(kw_live, tok_len, c);
                  tok_len = bump(tok_len);
                  taken = 1'b1;
               end else begin
                  close_pending();
               end
            end
            MODE_STRING: begin
               taken = 1'b1;
               if (c == CHAR_QUOTE && !escape_next) begin
                  close_pending();
               end else begin
                  escape_next = (c == CHAR_BACKSLASH) && !escape_next;
                  tok_len = bump(tok_len);
               end
            end
            default: ;
         endcase
         if (!taken) begin
            if (c == ";" || c == "(" || c == ")") begin
               add_token(KIND_SEPARATOR, text_pos, 16'd1, c);
            end else if (num_char(c)) begin
               cur_mode = MODE_NUMBER;
               tok_start = text_pos;
               tok_len = 16'd1;
            end else if (letter_char(c)) begin
               cur_mode = MODE_WORD;
               tok_start = text_pos;
               tok_len = 16'd1;
               kw_live = kw_filter(KW_ALL, 16'd0, c);
            end else if (op_char(c)) begin
               add_token(KIND_OPERATOR, text_pos, 16'd1, c);
            end else if (c == CHAR_QUOTE) begin
               cur_mode = MODE_STRING;
               tok_start = bump(text_pos);
               tok_len = 16'd0;
               escape_next = 1'b0;
            end
         end
         text_pos = bump(text_pos);
      end
      if (byte_tokens.size() > 0) begin
         byte_tokens[byte_tokens.size() - 1].is_last = 1'b1;
      end
   endfunction

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
   endfunction

   // string content after the opening quote, escapes and high bytes mixed in
   function automatic void put_string_body();
      int         n;
      logic [7:0] c;
      n = $urandom_range(0, 8);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0, 1: put_byte(CHAR_BACKSLASH);
            2: begin
               put_byte(CHAR_BACKSLASH);
               put_byte(CHAR_QUOTE);
            end
            default: begin
               c = 8'($urandom_range(1, 255));
               put_byte((c == CHAR_QUOTE) ? 8'h51 : c);
            end
         endcase
      end
   endfunction

   // one random text ending in a zero byte; mostly well formed, some pure noise
   function automatic void compose_text();
      int    pieces;
      int    n;
      string s;
      text_q.delete();
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 30);
         repeat (n) put_byte(8'($urandom_range(1, 255)));
      end else begin
         pieces = $urandom_range(1, 24);
         repeat (pieces) begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  s = kw_forms[$urandom_range(0, 13)];
                  for (int k = 0; k < s.len(); k++) put_byte(s[k]);
               end
               2: begin
                  put_byte(rand_letter());
                  n = $urandom_range(0, 6);
                  repeat (n) begin
                     case ($urandom_range(0, 3))
                        0: put_byte(8'h30 + 8'($urandom_range(0, 9)));
                        1: put_byte(CHAR_UNDERSCORE);
                        default: put_byte(rand_letter());
                     endcase
                  end
               end
               3: begin
                  n = ($urandom_range(0, 19) == 0) ? 40 : $urandom_range(1, 5);
                  repeat (n) put_byte(8'h30 + 8'($urandom_range(0, 9)));
               end
               4: begin
                  put_byte(CHAR_QUOTE);
                  put_string_body();
                  put_byte(CHAR_QUOTE);
               end
               5: begin
                  s = ";()";
                  put_byte(s[$urandom_range(0, 2)]);
               end
               6, 7: put_byte(OP_CHARS[$urandom_range(0, 10)]);
               8: put_byte(8'($urandom_range(1, 255)));
               default: put_byte(CHAR_UNDERSCORE);
            endcase
            if ($urandom_range(0, 2) != 0) begin
               s = " \t\n";
               put_byte(s[$urandom_range(0, 2)]);
            end
         end
         if ($urandom_range(0, 7) == 0) begin
            put_byte(CHAR_QUOTE);
            put_string_body();
         end
      end
      put_byte(CHAR_NUL);
   endfunction

   // one byte transfer, then a random gap at the end of a burst
   task automatic send_byte(input logic [7:0] ch, input logic [1:0] n_typed,
                            input token_rec_type t0, input token_rec_type t1);
      int gap;
      req_push <= 1'b1;
      req_character <= ch;
      @(posedge clock);
      while (req_full) @(posedge clock);
      scan_byte(ch);
      if (n_typed == 2'd0) begin
         foreach (byte_tokens[k]) tokens_due.insert(tokens_due.size(), byte_tokens[k]);
      end else begin
         tokens_due.insert(tokens_due.size(), t0);
         if (n_typed == 2'd2) tokens_due.insert(tokens_due.size(), t1);
      end
      bytes_sent++;
      if (ch == CHAR_NUL) texts_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_push <= 1'b0;
            req_character <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin
      token_rec_type got;
      token_rec_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = tk(rsp_token_kind, rsp_token_start, rsp_token_length, rsp_symbol,
                     rsp_last_of_run);
            checked++;
            if (rsp_token_kind < 4'd9) kind_seen[rsp_token_kind]++;
            if (tokens_due.size() == 0) begin
               errors++;
               $display({"%0t: token mismatch, expected no token; actual kind %0d start %0d ",
                         "length %0d symbol 0x%02h last %0b"}, $time,
                        got.kind, got.start, got.len, got.sym, got.is_last);
            end else begin
               want = tokens_due.pop_front();
               if (got !== want) begin
                  errors++;
                  $display({"%0t: token mismatch, expected kind %0d start %0d length %0d ",
                            "symbol 0x%02h last %0b; actual kind %0d start %0d length %0d ",
                            "symbol 0x%02h last %0b"}, $time,
                           want.kind, want.start, want.len, want.sym, want.is_last,
                           got.kind, got.start, got.len, got.sym, got.is_last);
               end
            end
         end
         if (pop_mode_left == 0) begin
            pop_mode = pop_style_type'($urandom_range(0, 2));
            pop_mode_left = $urandom_range(40, 400);
         end
         pop_mode_left--;
         case (pop_mode)
            POP_ALWAYS: pop_level = 1'b1;
            POP_RANDOM: pop_level = ($urandom_range(0, 3) != 0);
            default: begin
               if (pop_hold == 0) begin
                  pop_level = !pop_level;
                  pop_hold = $urandom_range(1, 20);
               end
               pop_hold--;
            end
         endcase
         rsp_pop <= pop_level;
      end
   end

   // ends the run when no transfer happens on either side for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      stim_row_type steps[$];
      string        tail;
      int unsigned  random_bytes;
      random_bytes = 0;

      steps.insert(steps.size(), row(CHAR_NUL, 2'd1,
                                     tk(KIND_END, 16'd0, 16'd0, 8'h00, 1'b1)));
      steps.insert(steps.size(), row("f"));
      steps.insert(steps.size(), row("u"));
      steps.insert(steps.size(), row("n"));
      steps.insert(steps.size(), row("c"));
      steps.insert(steps.size(), row("=", 2'd2,
                                     tk(KIND_FUNC, 16'd0, 16'd4, 8'h00, 1'b0),
                                     tk(KIND_OPERATOR, 16'd4, 16'd1, "=", 1'b1)));
      steps.insert(steps.size(), row(CHAR_UNDERSCORE));
      steps.insert(steps.size(), row(8'hff));
      steps.insert(steps.size(), row("0"));
      steps.insert(steps.size(), row("9"));
      steps.insert(steps.size(), row("x"));
      steps.insert(steps.size(), row(CHAR_UNDERSCORE));
      steps.insert(steps.size(), row(CHAR_QUOTE));
      steps.insert(steps.size(), row(CHAR_BACKSLASH));
      steps.insert(steps.size(), row(CHAR_QUOTE));
      steps.insert(steps.size(), row(CHAR_BACKSLASH));
      steps.insert(steps.size(), row(CHAR_BACKSLASH));
      steps.insert(steps.size(), row(CHAR_QUOTE));
      steps.insert(steps.size(), row(";"));
      steps.insert(steps.size(), row(CHAR_QUOTE));
      steps.insert(steps.size(), row(8'h80));
      steps.insert(steps.size(), row(CHAR_NUL));
      steps.insert(steps.size(), row("e"));
      steps.insert(steps.size(), row("x"));
      steps.insert(steps.size(), row("i"));
      steps.insert(steps.size(), row("t"));
      steps.insert(steps.size(), row(CHAR_NUL, 2'd2,
                                     tk(KIND_EXIT, 16'd0, 16'd4, 8'h00, 1'b0),
                                     tk(KIND_END, 16'd4, 16'd0, 8'h00, 1'b1)));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[k]) send_byte(steps[k].ch, steps[k].n_typed, steps[k].t0, steps[k].t1);

      // long number, then a string and word run into each other
      repeat (LONG_DIGITS) send_byte("7", 2'd0, '0, '0);
      tail = "\"a\"z;";
      for (int k = 0; k < tail.len(); k++) send_byte(tail[k], 2'd0, '0, '0);
      send_byte(CHAR_NUL, 2'd0, '0, '0);

      while (random_bytes < RANDOM_BYTES) begin
         compose_text();
         foreach (text_q[k]) send_byte(text_q[k], 2'd0, '0, '0);
         random_bytes += text_q.size();
      end
      req_push <= 1'b0;

      while (tokens_due.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("tokenizer: %0d bytes in %0d texts, %0d tokens checked, %0d mismatches",
               bytes_sent, texts_sent, checked, errors);
      $display({"kinds seen num %0d print %0d sep %0d ident %0d op %0d str %0d ",
                "exit %0d func %0d end %0d"},
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
               kind_seen[5], kind_seen[6], kind_seen[7], kind_seen[8]);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
